// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in the RTL. Each macro expects
// signals named clk and rst in the module that uses it.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cssc_pkg.sv =====
// ---------------------------------------------------------------------------
// Compressor speed and status control package
// Register indexes, mode and color codes, speed and duty constants, and the
// flash timing of the system pixel.
// ---------------------------------------------------------------------------
package cssc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEED     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_USER_SPEED    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT_HIGH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT_LOW  = 3'd5;

  localparam logic [2:0] MODE_OFF  = 3'd0;
  localparam logic [2:0] MODE_MIN  = 3'd1;
  localparam logic [2:0] MODE_MAX  = 3'd2;
  localparam logic [2:0] MODE_USER = 3'd3;
  localparam logic [2:0] MODE_MECH = 3'd4;
  localparam logic [2:0] MODE_BAND = 3'd5;

  localparam logic [2:0] COLOR_RED     = 3'd0;
  localparam logic [2:0] COLOR_CYAN    = 3'd1;
  localparam logic [2:0] COLOR_ORANGE  = 3'd2;
  localparam logic [2:0] COLOR_MAGENTA = 3'd3;
  localparam logic [2:0] COLOR_GREEN   = 3'd4;
  localparam logic [2:0] COLOR_BLUE    = 3'd5;
  localparam logic [2:0] COLOR_YELLOW  = 3'd6;
  localparam logic [2:0] COLOR_NONE    = 3'd7;

  localparam logic [1:0] WIFI_NONE    = 2'd0;
  localparam logic [1:0] WIFI_AP      = 2'd1;
  localparam logic [1:0] WIFI_STATION = 2'd2;
  localparam logic [1:0] WIFI_BOTH    = 2'd3;

  localparam logic [2:0]  RESET_MODE          = MODE_OFF;
  localparam logic [12:0] RESET_MIN_SPEED     = 13'd2000;
  localparam logic [12:0] RESET_MAX_SPEED     = 13'd3500;
  localparam logic [12:0] RESET_USER_SPEED    = 13'd2500;
  localparam logic signed [14:0] RESET_SETPOINT_HIGH = 15'sd500;
  localparam logic signed [14:0] RESET_SETPOINT_LOW  = 15'sd300;

  localparam int unsigned SPEED_FLOOR   = 2000;
  localparam int unsigned SPEED_CEIL    = 3500;
  localparam int unsigned SPEED_SPAN    = 1500;
  localparam int unsigned DUTY_AT_FLOOR = 244;
  localparam int unsigned DUTY_AT_CEIL  = 85;

  // The rounded-up quotient (d*159 + 1499) / 1500 is formed as one product
  // with the reciprocal 2^29/1500 rounded up, which is exact for d <= 1500.
  localparam int unsigned  DUTY_SHIFT = 29;
  localparam longint unsigned DUTY_RECIP =
    ((64'd1 << DUTY_SHIFT) + SPEED_SPAN - 1) / SPEED_SPAN;
  localparam longint unsigned DUTY_MULT =
    (DUTY_AT_FLOOR - DUTY_AT_CEIL) * DUTY_RECIP;
  localparam longint unsigned DUTY_BIAS = (SPEED_SPAN - 1) * DUTY_RECIP;
  localparam int unsigned DUTY_PROD_W = 38;

  localparam int unsigned FLASH_CYCLE_MS = 4000;
  localparam int unsigned FLASH_STEP_MS  = 250;

endpackage

// ===== rtl/compressor_speed_and_status_control_top.sv =====
// ---------------------------------------------------------------------------
// Compressor speed and status control
// Per control tick: picks the compressor speed from the mode, derives the PWM
// duty, and drives the system and state pixel colors with error flashing.
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   input    in_valid / in_stall  now_ms .. force_refresh, one tick request
//   output   out_valid/out_stall  speed .. show_pixels, one result request
//   config   cfg_write_en         cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; its result is offered
// once the logic pass behind the input register lands in the result register.
// Reset restores the register defaults and clears speed, error and flash state;
// the shown colors reset to none shown.
// in_stall rises only while the input register is full and the result
// register holds a stalled result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module compressor_speed_and_status_control_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [cssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cssc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [31:0]                         now_ms,
  input  logic                                power_on,
  input  logic                                fan_on,
  input  logic                                diag_on,
  input  logic                                mech_therm,
  input  logic signed [14:0]                  fridge_temp,
  input  logic                                temp_error,
  input  logic                                log_error,
  input  logic                                wifi_enabled,
  input  logic [1:0]                          wifi_status,
  input  logic                                hold_speed,
  input  logic                                force_refresh,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [11:0]                         speed,
  output logic [7:0]                          duty_cycle,
  output logic                                compressor_on,
  output logic [2:0]                          system_color,
  output logic [2:0]                          state_color,
  output logic                                show_pixels
);

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               power_on;
    logic               fan_on;
    logic               diag_on;
    logic               mech_therm;
    logic signed [14:0] fridge_temp;
    logic               temp_error;
    logic               log_error;
    logic               wifi_enabled;
    logic [1:0]         wifi_status;
    logic               hold_speed;
    logic               force_refresh;
  } tick_t;

  logic [2:0]         mode;
  logic [12:0]        min_speed;
  logic [12:0]        max_speed;
  logic [12:0]        user_speed;
  logic signed [14:0] setpoint_high;
  logic signed [14:0] setpoint_low;

  logic [11:0] current_speed;
  logic [1:0]  current_error_code;
  logic [31:0] flash_cycle_start;
  logic [2:0]  shown_system_color;
  logic [2:0]  shown_state_color;

  logic  tick_valid;
  tick_t tick;
  logic  advance;
  logic  accept;

  logic [12:0] rpm_req;
  logic [11:0] current_speed_next;
  logic [1:0]  current_error_code_next;
  logic [31:0] flash_cycle_start_next;
  logic [31:0] start_after_code;
  logic [31:0] since_ms;
  logic [10:0] flash_limit;
  logic        flash_red;
  logic [2:0]  sys_color_next;
  logic [2:0]  st_color_next;
  logic        sys_changed;
  logic        st_changed;
  logic [10:0] speed_offset;
  logic [cssc_pkg::DUTY_PROD_W-1:0] duty_prod;
  logic [7:0]  duty_step;
  logic [7:0]  duty_cycle_next;

  assign advance  = tick_valid && (!out_valid || !out_stall);
  assign in_stall = tick_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= cssc_pkg::RESET_MODE;
      min_speed     <= cssc_pkg::RESET_MIN_SPEED;
      max_speed     <= cssc_pkg::RESET_MAX_SPEED;
      user_speed    <= cssc_pkg::RESET_USER_SPEED;
      setpoint_high <= cssc_pkg::RESET_SETPOINT_HIGH;
      setpoint_low  <= cssc_pkg::RESET_SETPOINT_LOW;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        cssc_pkg::REG_MODE:          mode          <= cfg_data[2:0];
        cssc_pkg::REG_MIN_SPEED:     min_speed     <= cfg_data[12:0];
        cssc_pkg::REG_MAX_SPEED:     max_speed     <= cfg_data[12:0];
        cssc_pkg::REG_USER_SPEED:    user_speed    <= cfg_data[12:0];
        cssc_pkg::REG_SETPOINT_HIGH: setpoint_high <= $signed(cfg_data);
        cssc_pkg::REG_SETPOINT_LOW:  setpoint_low  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (accept) begin
      tick_valid <= 1'b1;
    end else if (advance) begin
      tick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick.now_ms        <= now_ms;
      tick.power_on      <= power_on;
      tick.fan_on        <= fan_on;
      tick.diag_on       <= diag_on;
      tick.mech_therm    <= mech_therm;
      tick.fridge_temp   <= fridge_temp;
      tick.temp_error    <= temp_error;
      tick.log_error     <= log_error;
      tick.wifi_enabled  <= wifi_enabled;
      tick.wifi_status   <= wifi_status;
      tick.hold_speed    <= hold_speed;
      tick.force_refresh <= force_refresh;
    end
  end

  always_comb begin
    rpm_req = '0;
    if (tick.power_on) begin
      unique case (mode)
        cssc_pkg::MODE_MIN:  rpm_req = min_speed;
        cssc_pkg::MODE_MAX:  rpm_req = max_speed;
        cssc_pkg::MODE_USER: rpm_req = user_speed;
        cssc_pkg::MODE_MECH: rpm_req = tick.mech_therm ? user_speed : '0;
        cssc_pkg::MODE_BAND: begin
          if (tick.fridge_temp > setpoint_high) begin
            rpm_req = user_speed;
          end else if (tick.fridge_temp < setpoint_low) begin
            rpm_req = '0;
          end else begin
            rpm_req = {1'b0, current_speed};
          end
        end
        default: rpm_req = '0;
      endcase
    end

    if (tick.hold_speed) begin
      current_speed_next = current_speed;
    end else if (rpm_req == '0) begin
      current_speed_next = '0;
    end else if (rpm_req > 13'(cssc_pkg::SPEED_CEIL)) begin
      current_speed_next = 12'(cssc_pkg::SPEED_CEIL);
    end else if (rpm_req < 13'(cssc_pkg::SPEED_FLOOR)) begin
      current_speed_next = 12'(cssc_pkg::SPEED_FLOOR);
    end else begin
      current_speed_next = rpm_req[11:0];
    end
  end

  always_comb begin
    speed_offset = 11'(current_speed_next - 12'(cssc_pkg::SPEED_FLOOR));
    duty_prod = cssc_pkg::DUTY_PROD_W'(speed_offset)
                * cssc_pkg::DUTY_PROD_W'(cssc_pkg::DUTY_MULT)
                + cssc_pkg::DUTY_PROD_W'(cssc_pkg::DUTY_BIAS);
    duty_step = 8'(duty_prod >> cssc_pkg::DUTY_SHIFT);
    if (current_speed_next == '0) begin
      duty_cycle_next = '0;
    end else begin
      duty_cycle_next = 8'(cssc_pkg::DUTY_AT_FLOOR) - duty_step;
    end
  end

  always_comb begin
    current_error_code_next = {tick.log_error, tick.temp_error};
    if (current_error_code_next != current_error_code) begin
      start_after_code = tick.now_ms;
    end else begin
      start_after_code = flash_cycle_start;
    end
    if (current_error_code_next != '0 &&
        (tick.now_ms - start_after_code) > 32'(cssc_pkg::FLASH_CYCLE_MS)) begin
      flash_cycle_start_next = tick.now_ms;
    end else begin
      flash_cycle_start_next = start_after_code;
    end
    since_ms    = tick.now_ms - flash_cycle_start_next;
    flash_limit = 11'(current_error_code_next) * 11'(2 * cssc_pkg::FLASH_STEP_MS);
    flash_red   = (current_error_code_next != '0) && (since_ms < 32'(flash_limit)) &&
                  ((since_ms >= 32'(1 * cssc_pkg::FLASH_STEP_MS) &&
                    since_ms <  32'(2 * cssc_pkg::FLASH_STEP_MS)) ||
                   (since_ms >= 32'(3 * cssc_pkg::FLASH_STEP_MS) &&
                    since_ms <  32'(4 * cssc_pkg::FLASH_STEP_MS)) ||
                   (since_ms >= 32'(5 * cssc_pkg::FLASH_STEP_MS) &&
                    since_ms <  32'(6 * cssc_pkg::FLASH_STEP_MS)));

    if (!tick.wifi_enabled) begin
      sys_color_next = cssc_pkg::COLOR_CYAN;
    end else begin
      unique case (tick.wifi_status)
        cssc_pkg::WIFI_BOTH:    sys_color_next = cssc_pkg::COLOR_ORANGE;
        cssc_pkg::WIFI_AP:      sys_color_next = cssc_pkg::COLOR_MAGENTA;
        cssc_pkg::WIFI_STATION: sys_color_next = cssc_pkg::COLOR_GREEN;
        cssc_pkg::WIFI_NONE:    sys_color_next = cssc_pkg::COLOR_RED;
        default:                sys_color_next = cssc_pkg::COLOR_RED;
      endcase
    end
    if (flash_red) begin
      sys_color_next = cssc_pkg::COLOR_RED;
    end

    priority if (tick.diag_on) begin
      st_color_next = cssc_pkg::COLOR_RED;
    end else if (current_speed_next != '0) begin
      st_color_next = cssc_pkg::COLOR_BLUE;
    end else if (tick.fan_on) begin
      st_color_next = cssc_pkg::COLOR_YELLOW;
    end else if (tick.power_on) begin
      st_color_next = cssc_pkg::COLOR_GREEN;
    end else begin
      st_color_next = cssc_pkg::COLOR_RED;
    end

    sys_changed = tick.force_refresh || (shown_system_color != sys_color_next);
    st_changed  = tick.force_refresh || (shown_state_color != st_color_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_speed      <= '0;
      current_error_code <= '0;
      flash_cycle_start  <= '0;
      shown_system_color <= cssc_pkg::COLOR_NONE;
      shown_state_color  <= cssc_pkg::COLOR_NONE;
    end else if (advance) begin
      current_speed      <= current_speed_next;
      current_error_code <= current_error_code_next;
      flash_cycle_start  <= flash_cycle_start_next;
      shown_system_color <= sys_color_next;
      shown_state_color  <= st_color_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      speed         <= current_speed_next;
      duty_cycle    <= duty_cycle_next;
      compressor_on <= (current_speed_next != '0);
      system_color  <= sys_color_next;
      state_color   <= st_color_next;
      show_pixels   <= sys_changed || st_changed;
    end
  end

  `CHK_SAME(a_stall_only_when_blocked, in_stall, out_valid && out_stall && tick_valid,
            "input stalled while the result register could take a request")
  `CHK_NEXT(a_advance_fills_result, advance, out_valid,
            "result register empty after a request advanced")
  `CHK_SAME(a_speed_in_band, out_valid && compressor_on,
            speed >= 12'(cssc_pkg::SPEED_FLOOR) && speed <= 12'(cssc_pkg::SPEED_CEIL),
            "running speed outside the allowed band")
  `CHK_SAME(a_duty_tracks_speed, out_valid,
            (duty_cycle == '0) == (speed == '0) && compressor_on == (speed != '0),
            "duty or indicator disagrees with the speed")
  `CHK_SAME(a_blue_means_running, out_valid && !compressor_on,
            state_color != cssc_pkg::COLOR_BLUE,
            "state pixel shows running while the compressor is stopped")

endmodule

// ===== test/tb_compressor_speed_and_status_control_top.sv =====
// ---------------------------------------------------------------------------
// Compressor speed and status control testbench
// Drives control ticks through the request channel with random gaps and
// backpressure, predicts speed, duty and pixel colors per tick, and compares
// every result field against the prediction. Registers are rewritten between
// phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_compressor_speed_and_status_control_top;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [31:0]        now;
    logic               power;
    logic               fan;
    logic               diag;
    logic               mech;
    logic signed [14:0] temp;
    logic               terr;
    logic               lerr;
    logic               wifi_on;
    logic [1:0]         wifi;
    logic               hold;
    logic               refresh;
  } tick_t;

  typedef struct packed {
    logic [11:0] rpm;
    logic [7:0]  duty;
    logic        on;
    logic [2:0]  sys;
    logic [2:0]  st;
    logic        show;
  } status_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write_en = 1'b0;
  logic [cssc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cssc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [31:0]            now_ms = '0;
  logic                   power_on = 1'b0;
  logic                   fan_on = 1'b0;
  logic                   diag_on = 1'b0;
  logic                   mech_therm = 1'b0;
  logic signed [14:0]     fridge_temp = '0;
  logic                   temp_error = 1'b0;
  logic                   log_error = 1'b0;
  logic                   wifi_enabled = 1'b0;
  logic [1:0]             wifi_status = '0;
  logic                   hold_speed = 1'b0;
  logic                   force_refresh = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [11:0]            speed;
  logic [7:0]             duty_cycle;
  logic                   compressor_on;
  logic [2:0]             system_color;
  logic [2:0]             state_color;
  logic                   show_pixels;

  compressor_speed_and_status_control_top u_top (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .now_ms(now_ms), .power_on(power_on), .fan_on(fan_on), .diag_on(diag_on),
    .mech_therm(mech_therm), .fridge_temp(fridge_temp), .temp_error(temp_error),
    .log_error(log_error), .wifi_enabled(wifi_enabled), .wifi_status(wifi_status),
    .hold_speed(hold_speed), .force_refresh(force_refresh),
    .out_valid(out_valid), .out_stall(out_stall),
    .speed(speed), .duty_cycle(duty_cycle), .compressor_on(compressor_on),
    .system_color(system_color), .state_color(state_color),
    .show_pixels(show_pixels)
  );

  // Register copies and control state of the prediction.
  logic [2:0]         cfg_mode = cssc_pkg::RESET_MODE;
  logic [12:0]        cfg_min = cssc_pkg::RESET_MIN_SPEED;
  logic [12:0]        cfg_max = cssc_pkg::RESET_MAX_SPEED;
  logic [12:0]        cfg_user = cssc_pkg::RESET_USER_SPEED;
  logic signed [14:0] cfg_sp_high = cssc_pkg::RESET_SETPOINT_HIGH;
  logic signed [14:0] cfg_sp_low = cssc_pkg::RESET_SETPOINT_LOW;
  logic [11:0]        rpm_now = '0;
  logic [1:0]         err_code = '0;
  logic [31:0]        flash_start = '0;
  logic [2:0]         shown_sys = cssc_pkg::COLOR_NONE;
  logic [2:0]         shown_st = cssc_pkg::COLOR_NONE;

  tick_t   tick_queue[$];
  status_t status_due[$];
  tick_t   offer;
  bit      offering = 1'b0;
  bit      gaps_on = 1'b1;
  bit      squeeze_req = 1'b0;
  bit      squeeze_done = 1'b0;
  int      tx_wait = 0;
  int      rx_wait = 0;
  int      rx_cycles = 0;
  int      next_long = 600;
  int      mismatches = 0;

  logic [31:0] walk_ms = '0;
  int          walk_temp = 0;
  logic [1:0]  walk_err = '0;
  logic        walk_wifi_on = 1'b0;
  logic [1:0]  walk_wifi = '0;
  logic        walk_mech = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic status_t next_status(tick_t t);
    status_t     r;
    logic [12:0] req;
    logic [1:0]  code;
    logic [31:0] since;
    logic [2:0]  sys_c;
    logic [2:0]  st_c;
    int unsigned d;
    r = '0;
    if (!t.hold) begin
      req = '0;
      if (t.power) begin
        case (cfg_mode)
          cssc_pkg::MODE_MIN:  req = cfg_min;
          cssc_pkg::MODE_MAX:  req = cfg_max;
          cssc_pkg::MODE_USER: req = cfg_user;
          cssc_pkg::MODE_MECH: req = t.mech ? cfg_user : 13'd0;
          cssc_pkg::MODE_BAND: begin
            if ($signed(t.temp) > cfg_sp_high) req = cfg_user;
            else if ($signed(t.temp) < cfg_sp_low) req = '0;
            else req = {1'b0, rpm_now};
          end
          default: req = '0;
        endcase
      end
      if (req == 0) rpm_now = '0;
      else if (req > cssc_pkg::SPEED_CEIL) rpm_now = 12'(cssc_pkg::SPEED_CEIL);
      else if (req < cssc_pkg::SPEED_FLOOR) rpm_now = 12'(cssc_pkg::SPEED_FLOOR);
      else rpm_now = req[11:0];
    end

    code = {t.lerr, t.terr};
    if (code != err_code) begin
      err_code = code;
      flash_start = t.now;
    end
    since = t.now - flash_start;
    if (err_code != 0 && since > cssc_pkg::FLASH_CYCLE_MS) flash_start = t.now;

    sys_c = cssc_pkg::COLOR_CYAN;
    if (t.wifi_on) begin
      case (t.wifi)
        cssc_pkg::WIFI_BOTH:    sys_c = cssc_pkg::COLOR_ORANGE;
        cssc_pkg::WIFI_AP:      sys_c = cssc_pkg::COLOR_MAGENTA;
        cssc_pkg::WIFI_STATION: sys_c = cssc_pkg::COLOR_GREEN;
        default:                sys_c = cssc_pkg::COLOR_RED;
      endcase
    end
    if (err_code != 0) begin
      since = t.now - flash_start;
      if (since < err_code * 2 * cssc_pkg::FLASH_STEP_MS &&
          (since / cssc_pkg::FLASH_STEP_MS) % 2 == 1)
        sys_c = cssc_pkg::COLOR_RED;
    end

    if (t.diag) st_c = cssc_pkg::COLOR_RED;
    else if (rpm_now != 0) st_c = cssc_pkg::COLOR_BLUE;
    else if (t.fan) st_c = cssc_pkg::COLOR_YELLOW;
    else if (t.power) st_c = cssc_pkg::COLOR_GREEN;
    else st_c = cssc_pkg::COLOR_RED;

    if (t.refresh || shown_sys != sys_c) begin
      shown_sys = sys_c;
      r.show = 1'b1;
    end
    if (t.refresh || shown_st != st_c) begin
      shown_st = st_c;
      r.show = 1'b1;
    end

    r.rpm = rpm_now;
    r.on = (rpm_now != 0);
    if (rpm_now != 0) begin
      d = rpm_now - cssc_pkg::SPEED_FLOOR;
      r.duty = 8'(cssc_pkg::DUTY_AT_FLOOR -
        (d * (cssc_pkg::DUTY_AT_FLOOR - cssc_pkg::DUTY_AT_CEIL) +
         cssc_pkg::SPEED_SPAN - 1) / cssc_pkg::SPEED_SPAN);
    end
    r.sys = sys_c;
    r.st = st_c;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_rpm();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1999;
      2: return cssc_pkg::SPEED_FLOOR;
      3: return cssc_pkg::SPEED_CEIL;
      4: return 3501;
      5: return 8191;
      6: return $urandom_range(0, 8191);
      default: return $urandom_range(cssc_pkg::SPEED_FLOOR, cssc_pkg::SPEED_CEIL);
    endcase
  endfunction

  // Ticks follow a running clock and a drifting temperature so that the
  // hysteresis band and the flash windows are crossed in realistic order.
  function automatic tick_t next_tick();
    tick_t t;
    t = '0;
    if ($urandom_range(0, 19) == 0) walk_ms = walk_ms + $urandom();
    else walk_ms = walk_ms + $urandom_range(0, 700);
    if ($urandom_range(0, 19) == 0) walk_temp = $urandom_range(0, 18000) - 5500;
    else walk_temp = walk_temp + $urandom_range(0, 80) - 40;
    if (walk_temp > 12500) walk_temp = 12500;
    if (walk_temp < -5500) walk_temp = -5500;
    if ($urandom_range(0, 24) == 0) walk_err = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 29) == 0) begin
      walk_wifi_on = 1'($urandom_range(0, 1));
      walk_wifi = 2'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 7) == 0) walk_mech = ~walk_mech;
    t.now = walk_ms;
    t.power = ($urandom_range(0, 15) != 0);
    t.fan = ($urandom_range(0, 3) == 0);
    t.diag = ($urandom_range(0, 15) == 0);
    t.mech = walk_mech;
    t.temp = walk_temp[14:0];
    t.terr = walk_err[0];
    t.lerr = walk_err[1];
    t.wifi_on = walk_wifi_on;
    t.wifi = walk_wifi;
    t.hold = ($urandom_range(0, 19) == 0);
    t.refresh = ($urandom_range(0, 15) == 0);
    return t;
  endfunction

  task automatic compare_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s: expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  task automatic set_reg(logic [cssc_pkg::CFG_INDEX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[cssc_pkg::CFG_DATA_W-1:0];
    case (idx)
      cssc_pkg::REG_MODE:          cfg_mode = val[2:0];
      cssc_pkg::REG_MIN_SPEED:     cfg_min = val[12:0];
      cssc_pkg::REG_MAX_SPEED:     cfg_max = val[12:0];
      cssc_pkg::REG_USER_SPEED:    cfg_user = val[12:0];
      cssc_pkg::REG_SETPOINT_HIGH: cfg_sp_high = val[14:0];
      cssc_pkg::REG_SETPOINT_LOW:  cfg_sp_low = val[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (tick_queue.size() != 0 || offering || status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_due.push_back(next_status(offer));
        offering = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          offer = tick_queue.pop_front();
          offering = 1'b1;
          now_ms <= offer.now;
          power_on <= offer.power;
          fan_on <= offer.fan;
          diag_on <= offer.diag;
          mech_therm <= offer.mech;
          fridge_temp <= offer.temp;
          temp_error <= offer.terr;
          log_error <= offer.lerr;
          wifi_enabled <= offer.wifi_on;
          wifi_status <= offer.wifi;
          hold_speed <= offer.hold;
          force_refresh <= offer.refresh;
          in_valid <= 1'b1;
          tx_wait = gaps_on ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    status_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, actual speed %0d", $time, speed);
        end else begin
          want = status_due.pop_front();
          compare_field("speed", want.rpm, speed);
          compare_field("duty_cycle", want.duty, duty_cycle);
          compare_field("compressor_on", want.on, compressor_on);
          compare_field("system_color", want.sys, system_color);
          compare_field("state_color", want.st, state_color);
          compare_field("show_pixels", want.show, show_pixels);
        end
      end
      rx_cycles++;
      if (rx_wait != 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (squeeze_req && !squeeze_done) begin
          rx_wait = 150;
          squeeze_done = 1'b1;
        end else if (rx_cycles >= next_long) begin
          rx_wait = 120;
          next_long += 1500;
        end else if (gaps_on) begin
          rx_wait = idle_len();
        end
      end
    end
  end

  initial begin
    tick_t t;
    int    m;
    int    lo;
    int    hi;
    int    swap;
    int    n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Power, fan, diagnostic and wifi combinations with the compressor off.
    t = '0;
    tick_queue.push_back(t);
    t.power = 1'b1;
    t.wifi_on = 1'b1;
    t.wifi = cssc_pkg::WIFI_NONE;
    t.now = 32'd10;
    tick_queue.push_back(t);
    t.fan = 1'b1;
    t.wifi = cssc_pkg::WIFI_BOTH;
    tick_queue.push_back(t);
    t.diag = 1'b1;
    t.wifi = cssc_pkg::WIFI_AP;
    tick_queue.push_back(t);
    t.diag = 1'b0;
    t.wifi = cssc_pkg::WIFI_STATION;
    tick_queue.push_back(t);
    t.refresh = 1'b1;
    tick_queue.push_back(t);
    wait_quiet();

    // Speed extremes and clamping in the fixed-speed and thermostat modes, with a held speed.
    set_reg(cssc_pkg::REG_MODE, cssc_pkg::MODE_MIN);
    set_reg(cssc_pkg::REG_MIN_SPEED, 0);
    t = '0;
    t.power = 1'b1;
    tick_queue.push_back(t);
    wait_quiet();
    set_reg(cssc_pkg::REG_MIN_SPEED, 1);
    tick_queue.push_back(t);
    wait_quiet();
    set_reg(cssc_pkg::REG_MODE, cssc_pkg::MODE_MAX);
    set_reg(cssc_pkg::REG_MAX_SPEED, 8191);
    tick_queue.push_back(t);
    t.hold = 1'b1;
    t.power = 1'b0;
    tick_queue.push_back(t);
    t.hold = 1'b0;
    tick_queue.push_back(t);
    wait_quiet();
    set_reg(cssc_pkg::REG_MODE, cssc_pkg::MODE_USER);
    set_reg(cssc_pkg::REG_USER_SPEED, 3499);
    t.power = 1'b1;
    tick_queue.push_back(t);
    wait_quiet();
    set_reg(cssc_pkg::REG_MODE, cssc_pkg::MODE_MECH);
    t.mech = 1'b1;
    tick_queue.push_back(t);
    t.mech = 1'b0;
    tick_queue.push_back(t);
    wait_quiet();

    // Temperature band at the setpoint extremes, then with crossed setpoints, then the spare mode codes.
    set_reg(cssc_pkg::REG_MODE, cssc_pkg::MODE_BAND);
    set_reg(cssc_pkg::REG_SETPOINT_HIGH, 12500);
    set_reg(cssc_pkg::REG_SETPOINT_LOW, -5500);
    t.temp = 15'sd12500;
    tick_queue.push_back(t);
    t.temp = -15'sd5500;
    tick_queue.push_back(t);
    wait_quiet();
    set_reg(cssc_pkg::REG_SETPOINT_HIGH, -5500);
    set_reg(cssc_pkg::REG_SETPOINT_LOW, 12500);
    t.temp = '0;
    tick_queue.push_back(t);
    t.temp = -15'sd5500;
    tick_queue.push_back(t);
    wait_quiet();
    set_reg(cssc_pkg::REG_MODE, MODE_SPARE_A);
    tick_queue.push_back(t);
    wait_quiet();
    set_reg(cssc_pkg::REG_MODE, MODE_SPARE_B);
    tick_queue.push_back(t);
    wait_quiet();

    // Error flashing across the clock wrap and a restarted flash cycle.
    t = '0;
    t.wifi_on = 1'b1;
    t.wifi = cssc_pkg::WIFI_STATION;
    t.terr = 1'b1;
    t.now = 32'hFFFF_FF00;
    tick_queue.push_back(t);
    t.now += 300;
    tick_queue.push_back(t);
    t.now += 300;
    tick_queue.push_back(t);
    t.lerr = 1'b1;
    t.now += 5000;
    tick_queue.push_back(t);
    t.now += 4001;
    tick_queue.push_back(t);
    t.now += 260;
    tick_queue.push_back(t);
    wait_quiet();

    for (int ph = 0; ph < 12; ph++) begin
      m = $urandom_range(0, 9);
      set_reg(cssc_pkg::REG_MODE, (m > 7) ? cssc_pkg::MODE_BAND : m);
      set_reg(cssc_pkg::REG_MIN_SPEED, pick_rpm());
      set_reg(cssc_pkg::REG_MAX_SPEED, pick_rpm());
      set_reg(cssc_pkg::REG_USER_SPEED, pick_rpm());
      lo = $urandom_range(0, 18000) - 5500;
      hi = lo + $urandom_range(0, 800);
      if (hi > 12500) hi = 12500;
      if ($urandom_range(0, 5) == 0) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      set_reg(cssc_pkg::REG_SETPOINT_HIGH, hi);
      set_reg(cssc_pkg::REG_SETPOINT_LOW, lo);
      walk_temp = (lo + hi) / 2;
      walk_ms = $urandom();
      gaps_on = (ph == 0) || ($urandom_range(0, 3) != 0);
      n = $urandom_range(70, 100);
      repeat (n) tick_queue.push_back(next_tick());
      if (ph == 0) squeeze_req = 1'b1;
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("compressor_speed_and_status_control_top regression: pass");
    end else begin
      $display("compressor_speed_and_status_control_top regression: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("compressor_speed_and_status_control_top regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cssc_pkg.sv
rtl/compressor_speed_and_status_control_top.sv
test/tb_compressor_speed_and_status_control_top.sv
